// ----- rtl/flqg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and constants of the frame load quality governor.
// No dependencies; every other file refers to this package by scoped names.
package flqg_pkg;

  // Window geometry.
  localparam int WINDOW_DEPTH = 64;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int LEVEL_W  = 9;
  localparam int SUM_W    = SAMPLE_W + WIN_AW;
  localparam int ITER_W   = $clog2(SAMPLE_W);
  localparam int NUM_LEVELS = 5;
  localparam int MOTION_IDX = 4;

  // Stream words.
  localparam int IN_W      = 48;
  localparam int OUT_BITS  = 1 + SAMPLE_W + 2 + 1 + NUM_LEVELS * LEVEL_W;
  localparam int OUT_W     = 72;
  localparam int OUT_PAD   = OUT_W - OUT_BITS;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WARNING  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REDUCE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESTORE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd5;

  // Level constants in Q1.8.
  localparam logic [LEVEL_W-1:0] LEVEL_FULL   = 9'd256;
  localparam logic [LEVEL_W-1:0] MOTION_FLOOR = 9'd77;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef level_t levels_t [NUM_LEVELS];

  typedef enum logic [1:0] {
    GRADE_OPTIMAL  = 2'd0,
    GRADE_WARNING  = 2'd1,
    GRADE_CRITICAL = 2'd2
  } grade_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_DIV,
    ST_GRADE,
    ST_ADJ,
    ST_ADJ2,
    ST_OUT
  } state_t;

  // One level step request: reduce, or restore when restore is set.
  typedef struct packed {
    logic valid;
    logic restore;
  } lvl_cmd_t;

endpackage

// ----- rtl/flqg_window.sv -----
`timescale 1ns / 1ps
// Ring window of frame-time samples with running sum and fill count.
// Depends on flqg_pkg.
module flqg_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [flqg_pkg::SAMPLE_W-1:0] sample,
  output logic [flqg_pkg::SUM_W-1:0]    sum,
  output logic [flqg_pkg::CNT_W-1:0]    count,
  output logic                          busy,
  output logic                          done
);

  localparam logic [flqg_pkg::CNT_W-1:0] DEPTH_CNT  = flqg_pkg::CNT_W'(flqg_pkg::WINDOW_DEPTH);
  localparam logic [flqg_pkg::WIN_AW-1:0] LAST_SLOT =
    flqg_pkg::WIN_AW'(flqg_pkg::WINDOW_DEPTH - 1);

  logic [flqg_pkg::SAMPLE_W-1:0] mem [flqg_pkg::WINDOW_DEPTH];
  logic [flqg_pkg::SAMPLE_W-1:0] old_data;
  logic [flqg_pkg::SAMPLE_W-1:0] sample_r;
  logic [flqg_pkg::WIN_AW-1:0]   slot;
  logic                          upd;
  logic                          full;
  logic [flqg_pkg::SUM_W-1:0]    sum_next;

  assign full = (count == DEPTH_CNT);
  assign busy = upd;

  // The oldest entry is only subtracted once the window has wrapped.
  always_comb begin
    if (full) begin
      sum_next = sum - flqg_pkg::SUM_W'(old_data) + flqg_pkg::SUM_W'(sample_r);
    end else begin
      sum_next = sum + flqg_pkg::SUM_W'(sample_r);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      old_data <= mem[slot];
      sample_r <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      mem[slot] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= '0;
      count <= '0;
      sum   <= '0;
      upd   <= 1'b0;
      done  <= 1'b0;
    end else begin
      upd  <= start;
      done <= upd;
      if (upd) begin
        sum  <= sum_next;
        slot <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
        if (!full) begin
          count <= count + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/flqg_div.sv -----
`timescale 1ns / 1ps
// Bit-serial restoring divider producing the 16-bit window mean.
// Depends on flqg_pkg.
module flqg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [flqg_pkg::SUM_W-1:0]    dividend,
  input  logic [flqg_pkg::CNT_W-1:0]    divisor,
  output logic [flqg_pkg::SAMPLE_W-1:0] quotient,
  output logic                          busy,
  output logic                          done
);

  localparam logic [flqg_pkg::ITER_W-1:0] LAST_ITER = flqg_pkg::ITER_W'(flqg_pkg::SAMPLE_W - 1);

  logic [flqg_pkg::CNT_W-1:0]    rem;
  logic [flqg_pkg::SAMPLE_W-1:0] shreg;
  logic [flqg_pkg::ITER_W-1:0]   iter;
  logic [flqg_pkg::CNT_W:0]      trial;
  logic [flqg_pkg::CNT_W:0]      diff;
  logic                          ge;

  // The mean of 16-bit samples fits 16 bits, so the upper dividend bits are
  // already below the divisor and only 16 quotient bits remain to be found.
  assign trial = {rem, shreg[flqg_pkg::SAMPLE_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});
  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= flqg_pkg::CNT_W'(dividend[flqg_pkg::SUM_W-1:flqg_pkg::SAMPLE_W]);
      shreg <= dividend[flqg_pkg::SAMPLE_W-1:0];
    end else if (busy) begin
      rem   <= ge ? diff[flqg_pkg::CNT_W-1:0] : trial[flqg_pkg::CNT_W-1:0];
      shreg <= {shreg[flqg_pkg::SAMPLE_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == LAST_ITER) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/flqg_levels.sv -----
`timescale 1ns / 1ps
// Five Q1.8 quality levels with saturating reduce and restore steps.
// Depends on flqg_pkg.
module flqg_levels (
  input  logic                         clk,
  input  logic                         rst,
  input  flqg_pkg::lvl_cmd_t           cmd,
  input  logic [flqg_pkg::LEVEL_W-1:0] reduce_step,
  input  logic [flqg_pkg::LEVEL_W-1:0] restore_step,
  output flqg_pkg::levels_t            levels
);

  flqg_pkg::levels_t             levels_next;
  logic [flqg_pkg::LEVEL_W-2:0]  red_half;
  logic [flqg_pkg::LEVEL_W-2:0]  res_half;
  logic [flqg_pkg::LEVEL_W:0]    up_sum;
  logic [flqg_pkg::LEVEL_W:0]    floor_sum;

  assign red_half = reduce_step[flqg_pkg::LEVEL_W-1:1];
  assign res_half = restore_step[flqg_pkg::LEVEL_W-1:1];
  assign floor_sum = {1'b0, flqg_pkg::MOTION_FLOOR} + {2'b00, red_half};

  always_comb begin
    up_sum = '0;
    for (int i = 0; i < flqg_pkg::MOTION_IDX; i++) begin
      if (cmd.restore) begin
        up_sum = {1'b0, levels[i]} + {1'b0, restore_step};
        levels_next[i] = (up_sum > {1'b0, flqg_pkg::LEVEL_FULL}) ?
                         flqg_pkg::LEVEL_FULL : up_sum[flqg_pkg::LEVEL_W-1:0];
      end else begin
        levels_next[i] = (levels[i] > reduce_step) ? levels[i] - reduce_step : '0;
      end
    end
    // Motion scale moves by half a step and never drops under its floor.
    if (cmd.restore) begin
      up_sum = {1'b0, levels[flqg_pkg::MOTION_IDX]} + {2'b00, res_half};
      levels_next[flqg_pkg::MOTION_IDX] = (up_sum > {1'b0, flqg_pkg::LEVEL_FULL}) ?
        flqg_pkg::LEVEL_FULL : up_sum[flqg_pkg::LEVEL_W-1:0];
    end else begin
      levels_next[flqg_pkg::MOTION_IDX] =
        ({1'b0, levels[flqg_pkg::MOTION_IDX]} >= floor_sum) ?
        levels[flqg_pkg::MOTION_IDX] - {1'b0, red_half} : flqg_pkg::MOTION_FLOOR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < flqg_pkg::NUM_LEVELS; i++) begin
        levels[i] <= flqg_pkg::LEVEL_FULL;
      end
    end else if (cmd.valid) begin
      levels <= levels_next;
    end
  end

endmodule

// ----- rtl/frame_load_quality_governor.sv -----
`timescale 1ns / 1ps
// Top level of the frame load quality governor: control, grading, cooldown.
// Depends on flqg_pkg, flqg_window, flqg_div and flqg_levels.
//
//  Channel   Direction  Handshake          Words
//  s_*       in         s_tvalid/s_tready  one frame-time sample with timestamp
//  m_*       out        m_tvalid/m_tready  one result word per input word
//  cfg_*     in         cfg_we             register writes, no read-back
//
// A nonzero word passes through the window (kick, registered memory read,
// then write and sum update), the bit-serial divider (load and 16 quotient
// bits), grading and cooldown, up to two level steps and the output register
// load, one word at a time. A zero word goes straight to the output stage.
// The input is ready again in the cycle after the result is loaded. Reset
// (rst, synchronous) restores the register defaults, empties the window and
// sets every level to full. The result sits in an output register, so the
// next word is taken while a stalled result waits for m_tready.
module frame_load_quality_governor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [15:0] frame_time, [47:16] now_ms
  input  logic [flqg_pkg::IN_W-1:0]       s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] accepted, [16:1] mean_frame_time, [18:17] load_level, [19] adjusted,
  // [28:20] rain_density, [37:29] particle_density, [46:38] animation_intensity,
  // [55:47] constellation_density, [64:56] motion_scale, [71:65] zero
  output logic [flqg_pkg::OUT_W-1:0]      m_tdata,
  input  logic                            cfg_we,
  input  logic [flqg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [flqg_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [flqg_pkg::SAMPLE_W-1:0] warning_threshold;
  logic [flqg_pkg::SAMPLE_W-1:0] critical_threshold;
  logic [flqg_pkg::SAMPLE_W-1:0] cooldown_ms;
  logic [flqg_pkg::LEVEL_W-1:0]  reduce_step;
  logic [flqg_pkg::LEVEL_W-1:0]  restore_step;
  logic                          hold_levels;

  flqg_pkg::state_t state;
  flqg_pkg::state_t state_next;

  // Per-word registers.
  logic [flqg_pkg::SAMPLE_W-1:0] sample;
  logic [flqg_pkg::TIME_W-1:0]   now_r;
  logic                          accepted_r;
  logic                          adjusted_r;

  // Held state kept across words; mean and grade are shown on every result.
  logic [flqg_pkg::SAMPLE_W-1:0] mean_value;
  flqg_pkg::grade_t              grade;
  logic [flqg_pkg::TIME_W-1:0]   last_adjust_ms;
  logic                          seen_first;

  logic                          s_fire;
  logic                          win_start;
  logic                          div_start;
  logic                          out_load;
  flqg_pkg::lvl_cmd_t            lvl_cmd;

  logic [flqg_pkg::SUM_W-1:0]    win_sum;
  logic [flqg_pkg::CNT_W-1:0]    win_count;
  logic                          win_busy;
  logic                          win_done;
  logic [flqg_pkg::SAMPLE_W-1:0] quotient;
  logic                          div_busy;
  logic                          div_done;
  flqg_pkg::levels_t             levels;

  flqg_pkg::grade_t              grade_new;
  logic [flqg_pkg::TIME_W-1:0]   last_eff;
  logic [flqg_pkg::TIME_W-1:0]   elapsed;
  logic                          cool_ok;

  assign s_fire = s_tvalid && s_tready;

  flqg_window u_window (
    .clk    (clk),
    .rst    (rst),
    .start  (win_start),
    .sample (sample),
    .sum    (win_sum),
    .count  (win_count),
    .busy   (win_busy),
    .done   (win_done)
  );

  flqg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (win_sum),
    .divisor  (win_count),
    .quotient (quotient),
    .busy     (div_busy),
    .done     (div_done)
  );

  flqg_levels u_levels (
    .clk          (clk),
    .rst          (rst),
    .cmd          (lvl_cmd),
    .reduce_step  (reduce_step),
    .restore_step (restore_step),
    .levels       (levels)
  );

  // Grade of the fresh mean, and time since the last adjustment point. The
  // first accepted sample becomes its own adjustment point.
  always_comb begin
    if (quotient >= critical_threshold) begin
      grade_new = flqg_pkg::GRADE_CRITICAL;
    end else if (quotient >= warning_threshold) begin
      grade_new = flqg_pkg::GRADE_WARNING;
    end else begin
      grade_new = flqg_pkg::GRADE_OPTIMAL;
    end
    last_eff = seen_first ? last_adjust_ms : now_r;
    elapsed  = now_r - last_eff;
    cool_ok  = (elapsed >= flqg_pkg::TIME_W'(cooldown_ms));
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      flqg_pkg::ST_IDLE: begin
        if (s_fire) begin
          state_next = (s_tdata[flqg_pkg::SAMPLE_W-1:0] != '0) ?
                       flqg_pkg::ST_WIN : flqg_pkg::ST_OUT;
        end
      end
      flqg_pkg::ST_WIN: begin
        if (win_done) begin
          state_next = flqg_pkg::ST_DIV;
        end
      end
      flqg_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = flqg_pkg::ST_GRADE;
        end
      end
      flqg_pkg::ST_GRADE: begin
        state_next = (cool_ok && !hold_levels) ? flqg_pkg::ST_ADJ : flqg_pkg::ST_OUT;
      end
      flqg_pkg::ST_ADJ: begin
        state_next = (grade == flqg_pkg::GRADE_CRITICAL) ? flqg_pkg::ST_ADJ2 :
                     flqg_pkg::ST_OUT;
      end
      flqg_pkg::ST_ADJ2: begin
        state_next = flqg_pkg::ST_OUT;
      end
      flqg_pkg::ST_OUT: begin
        if (out_load) begin
          state_next = flqg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = flqg_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    s_tready    = 1'b0;
    win_start   = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    lvl_cmd     = '0;
    unique case (state)
      flqg_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      flqg_pkg::ST_WIN: begin
        // The window is kicked in the cycle after acceptance, from the sample register.
        win_start = !win_busy && !win_done && (sample != '0);
        div_start = win_done;
      end
      flqg_pkg::ST_ADJ: begin
        lvl_cmd.valid   = 1'b1;
        lvl_cmd.restore = (grade == flqg_pkg::GRADE_OPTIMAL);
      end
      flqg_pkg::ST_ADJ2: begin
        lvl_cmd.valid = 1'b1;
      end
      flqg_pkg::ST_OUT: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      warning_threshold  <= 16'd5120;
      critical_threshold <= 16'd8448;
      cooldown_ms        <= 16'd1000;
      reduce_step        <= 9'd13;
      restore_step       <= 9'd5;
      hold_levels        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        flqg_pkg::REG_WARNING:  warning_threshold  <= cfg_data;
        flqg_pkg::REG_CRITICAL: critical_threshold <= cfg_data;
        flqg_pkg::REG_COOLDOWN: cooldown_ms        <= cfg_data;
        flqg_pkg::REG_REDUCE:   reduce_step        <= cfg_data[flqg_pkg::LEVEL_W-1:0];
        flqg_pkg::REG_RESTORE:  restore_step       <= cfg_data[flqg_pkg::LEVEL_W-1:0];
        flqg_pkg::REG_HOLD:     hold_levels        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Word registers, captured at acceptance and during grading.
  always_ff @(posedge clk) begin
    if (s_fire) begin
      sample     <= s_tdata[flqg_pkg::SAMPLE_W-1:0];
      now_r      <= s_tdata[flqg_pkg::IN_W-1:flqg_pkg::SAMPLE_W];
      accepted_r <= (s_tdata[flqg_pkg::SAMPLE_W-1:0] != '0);
      adjusted_r <= 1'b0;
    end else if (state == flqg_pkg::ST_GRADE) begin
      adjusted_r <= cool_ok && !hold_levels;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= flqg_pkg::ST_IDLE;
      mean_value     <= '0;
      grade          <= flqg_pkg::GRADE_OPTIMAL;
      last_adjust_ms <= '0;
      seen_first     <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == flqg_pkg::ST_GRADE) begin
        mean_value     <= quotient;
        grade          <= grade_new;
        seen_first     <= 1'b1;
        // The adjustment point moves on cooldown even while levels are held.
        last_adjust_ms <= cool_ok ? now_r : last_eff;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output register; payload needs no reset.
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{flqg_pkg::OUT_PAD{1'b0}},
                  levels[4], levels[3], levels[2], levels[1], levels[0],
                  adjusted_r, grade, mean_value, accepted_r};
    end
  end

  // The sequencer never takes a word while the window or divider is working.
  assert property (@(posedge clk) disable iff (rst)
    (win_busy || div_busy) |-> !s_tready)
    else $error("input taken while a word is still in flight");

  // A result reporting an adjustment must also report an accepted sample.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[19]) |-> m_tdata[0])
    else $error("adjustment reported on an ignored sample");

  // Motion scale never falls below its floor.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[64:56] >= flqg_pkg::MOTION_FLOOR))
    else $error("motion scale under floor");

  // The divider is only started once the window update has landed.
  assert property (@(posedge clk) disable iff (rst)
    div_start |-> $past(win_busy))
    else $error("divider started before the window sum was updated");

endmodule
